[design/efw_pkg.sv]
`timescale 1ns / 1ps
// Shared widths and constants for the earliest-free-worker scheduler.
package efw_pkg;

    localparam int DUR_W = 32;
    localparam int TIME_W = 48;
    localparam int IDX_OUT_W = 4;
    localparam int CNT_W = 5;

    localparam logic [CNT_W-1:0] COUNT_RESET = 5'd16;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

endpackage

[design/efw_free_bank.sv]
`timescale 1ns / 1ps
// Next-free time register bank, one entry per worker, single write port.
module efw_free_bank #(
    parameter int MAX_WORKERS = 16,
    parameter int IDX_W = 4
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      we,
    input  logic [IDX_W-1:0]                          wsel,
    input  logic [efw_pkg::TIME_W-1:0]                wdata,
    output logic [MAX_WORKERS*efw_pkg::TIME_W-1:0]    free_times
);

    logic [efw_pkg::TIME_W-1:0] free_time_reg [MAX_WORKERS];

    for (genvar i = 0; i < MAX_WORKERS; i++) begin : g_entry
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                free_time_reg[i] <= '0;
            end
            else if (we && (wsel == IDX_W'(i)))
            begin
                free_time_reg[i] <= wdata;
            end
        end

        assign free_times[i*efw_pkg::TIME_W +: efw_pkg::TIME_W] = free_time_reg[i];
    end

endmodule

[design/efw_argmin.sv]
`timescale 1ns / 1ps
// Comparator tree: lowest-index active worker with the smallest next-free time.
module efw_argmin #(
    parameter int MAX_WORKERS = 16,
    parameter int IDX_W = 4
) (
    input  logic [MAX_WORKERS*efw_pkg::TIME_W-1:0] free_times,
    input  logic [efw_pkg::CNT_W-1:0]              worker_count,
    output logic [IDX_W-1:0]                       best_idx,
    output logic [efw_pkg::TIME_W-1:0]             best_time
);

    localparam int LEAVES = 1 << IDX_W;
    localparam int NODES = 2 * LEAVES - 1;
    localparam int CMP_W = IDX_W + efw_pkg::CNT_W + 1;

    typedef struct packed {
        logic                       vld;
        logic [IDX_W-1:0]           idx;
        logic [efw_pkg::TIME_W-1:0] ftime;
    } node_t;

    node_t node [NODES];

    for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
        if (i < MAX_WORKERS) begin : g_real
            // worker 0 is always active, which covers a count of zero
            assign node[LEAVES-1+i].vld = (i == 0) ||
                (CMP_W'(i) < CMP_W'(worker_count));
            assign node[LEAVES-1+i].idx = IDX_W'(i);
            assign node[LEAVES-1+i].ftime =
                free_times[i*efw_pkg::TIME_W +: efw_pkg::TIME_W];
        end
        else begin : g_pad
            assign node[LEAVES-1+i] = '0;
        end
    end

    for (genvar k = 0; k < LEAVES - 1; k++) begin : g_node
        logic take_left;

        // left child always holds the lower indexes, so ties go left
        assign take_left = node[2*k+1].vld &&
            (!node[2*k+2].vld || (node[2*k+1].ftime <= node[2*k+2].ftime));
        assign node[k] = take_left ? node[2*k+1] : node[2*k+2];
    end

    assign best_idx = node[0].idx;
    assign best_time = node[0].ftime;

endmodule

[design/earliest_free_worker_scheduler_top.sv]
`timescale 1ns / 1ps
// Earliest-free-worker job scheduler top level.
//
// Each request carries one job duration. The block picks, among workers below
// worker_count (treated as 1 when zero, clamped to MAX_WORKERS), the one with
// the smallest next-free time (ties to the lower index), returns its index
// and that time as the start time, and adds the duration to it, saturating at
// 2^48-1. Next-free times reset to zero. Throughput is one request per cycle.
// From input acceptance to result valid the request waits in the input
// register, where the comparator tree and the saturating add run against
// the worker time bank, and is then loaded into the result register. A
// stalled result holds the input register, which stalls the input.
// worker_count may be written only while no request is in flight.
module earliest_free_worker_scheduler_top #(
    parameter int MAX_WORKERS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [efw_pkg::CNT_W-1:0]         cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [efw_pkg::DUR_W-1:0]         duration,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [efw_pkg::IDX_OUT_W-1:0]     worker_index,
    output logic [efw_pkg::TIME_W-1:0]        start_time
);

    localparam int IDX_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;

    logic [efw_pkg::CNT_W-1:0]            worker_count_reg;
    logic                                 s1_valid_reg;
    logic                                 s1_valid_next;
    logic [efw_pkg::DUR_W-1:0]            s1_dur_reg;
    logic                                 out_valid_reg;
    logic                                 out_valid_next;
    logic [efw_pkg::IDX_OUT_W-1:0]        out_idx_reg;
    logic [efw_pkg::TIME_W-1:0]           out_time_reg;

    logic                                 in_accept;
    logic                                 commit;
    logic [MAX_WORKERS*efw_pkg::TIME_W-1:0] free_times;
    logic [IDX_W-1:0]                     best_idx;
    logic [efw_pkg::TIME_W-1:0]           best_time;
    logic [efw_pkg::TIME_W:0]             sum;
    logic [efw_pkg::TIME_W-1:0]           new_time;
    logic [IDX_W+efw_pkg::IDX_OUT_W-1:0]  idx_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            worker_count_reg <= efw_pkg::COUNT_RESET;
        end
        else if (cfg_we)
        begin
            worker_count_reg <= cfg_wdata;
        end
    end

    // request moves from input register to result register
    assign commit = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !commit;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (commit)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_dur_reg <= duration;
        end
        if (commit)
        begin
            out_idx_reg <= idx_ext[efw_pkg::IDX_OUT_W-1:0];
            out_time_reg <= best_time;
        end
    end

    efw_free_bank #(
        .MAX_WORKERS (MAX_WORKERS),
        .IDX_W       (IDX_W)
    ) u_bank (
        .clk        (clk),
        .rst_n      (rst_n),
        .we         (commit),
        .wsel       (best_idx),
        .wdata      (new_time),
        .free_times (free_times)
    );

    efw_argmin #(
        .MAX_WORKERS (MAX_WORKERS),
        .IDX_W       (IDX_W)
    ) u_argmin (
        .free_times   (free_times),
        .worker_count (worker_count_reg),
        .best_idx     (best_idx),
        .best_time    (best_time)
    );

    assign sum = {1'b0, best_time} + (efw_pkg::TIME_W + 1)'(s1_dur_reg);
    assign new_time = sum[efw_pkg::TIME_W] ? efw_pkg::TIME_MAX : sum[efw_pkg::TIME_W-1:0];
    assign idx_ext = (IDX_W + efw_pkg::IDX_OUT_W)'(best_idx);

    assign out_valid = out_valid_reg;
    assign worker_index = out_idx_reg;
    assign start_time = out_time_reg;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled with a free stage");

    a_commit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> out_valid_reg)
        else $error("committed request did not reach the result register");

    a_pick_active: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (best_idx == '0) ||
            ((IDX_W + efw_pkg::CNT_W)'(best_idx) <
             (IDX_W + efw_pkg::CNT_W)'(worker_count_reg)))
        else $error("selected worker is not active");

    a_time_grows: assert property (@(posedge clk) disable iff (!rst_n)
        commit |-> new_time >= best_time)
        else $error("worker next-free time decreased");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the earliest-free-worker job scheduler.
module tb_top;

    localparam int MAX_WORKERS = 16;
    localparam int IDLE_LIMIT = 2000;
    localparam int NUM_DIRECTED = 24;
    localparam int NUM_PHASES = 8;
    localparam logic [efw_pkg::DUR_W-1:0] DUR_MAX = {efw_pkg::DUR_W{1'b1}};

    typedef struct {
        logic [efw_pkg::IDX_OUT_W-1:0] worker;
        logic [efw_pkg::TIME_W-1:0]    start;
    } assignment_t;

    typedef struct {
        logic [efw_pkg::DUR_W-1:0]     dur;
        bit                            known;
        logic [efw_pkg::IDX_OUT_W-1:0] worker;
        logic [efw_pkg::TIME_W-1:0]    start;
    } directed_job_t;

    typedef struct {
        logic [efw_pkg::CNT_W-1:0] count;
        int                        jobs;
        int                        send_idle_pct;
        int                        recv_stall_pct;
        int                        hold_off;
    } phase_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_we = 1'b0;
    logic [efw_pkg::CNT_W-1:0]     cfg_wdata = '0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic [efw_pkg::DUR_W-1:0]     duration = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [efw_pkg::IDX_OUT_W-1:0] worker_index;
    logic [efw_pkg::TIME_W-1:0]    start_time;

    logic [efw_pkg::TIME_W-1:0]    worker_free_time [MAX_WORKERS];
    logic [efw_pkg::CNT_W-1:0]     worker_count_setting;
    assignment_t                   pending_assignments [$];
    assignment_t                   oldest_assignment;
    int                            mismatches = 0;
    int                            quiet_cycles = 0;
    int                            send_idle_pct = 0;
    int                            recv_stall_pct = 0;
    int                            hold_left = 0;

    directed_job_t directed_jobs [NUM_DIRECTED] = '{
        '{32'h0000_0000, 1'b1, 4'd0, 48'd0},
        '{32'hFFFF_FFFF, 1'b1, 4'd0, 48'd0},
        '{32'h0000_0001, 1'b1, 4'd1, 48'd0},
        '{32'h8000_0000, 1'b1, 4'd2, 48'd0},
        '{32'h5555_5555, 1'b1, 4'd3, 48'd0},
        '{32'hAAAA_AAAA, 1'b1, 4'd4, 48'd0},
        '{32'h0000_FFFF, 1'b1, 4'd5, 48'd0},
        '{32'hFFFF_0000, 1'b1, 4'd6, 48'd0},
        '{32'h1234_5678, 1'b1, 4'd7, 48'd0},
        '{32'h0000_0002, 1'b1, 4'd8, 48'd0},
        '{32'h7FFF_FFFF, 1'b1, 4'd9, 48'd0},
        '{32'h0F0F_0F0F, 1'b1, 4'd10, 48'd0},
        '{32'hF0F0_F0F0, 1'b1, 4'd11, 48'd0},
        '{32'h0000_0100, 1'b1, 4'd12, 48'd0},
        '{32'hDEAD_BEEF, 1'b1, 4'd13, 48'd0},
        '{32'h0000_0010, 1'b1, 4'd14, 48'd0},
        '{32'hFFFF_FFFE, 1'b1, 4'd15, 48'd0},
        '{32'h0000_0000, 1'b1, 4'd1, 48'd1},
        '{32'h0000_0007, 1'b1, 4'd1, 48'd1},
        '{32'h0000_0003, 1'b0, 4'd0, 48'd0},
        '{32'h0000_0000, 1'b0, 4'd0, 48'd0},
        '{32'hFFFF_FFFF, 1'b0, 4'd0, 48'd0},
        '{32'h0000_0001, 1'b0, 4'd0, 48'd0},
        '{32'h0000_0004, 1'b0, 4'd0, 48'd0}
    };

    // count, jobs, sender idle %, receiver stall %, long hold-off cycles
    phase_t phases [NUM_PHASES] = '{
        '{5'd16, 80, 0, 0, 0},
        '{5'd1, 40, 48, 0, 0},
        '{5'd0, 30, 0, 48, 0},
        '{5'd31, 80, 26, 26, 0},
        '{5'd5, 60, 0, 0, 80},
        '{5'd17, 60, 48, 0, 0},
        '{5'd3, 60, 0, 48, 0},
        '{5'd16, 90, 26, 26, 0}
    };

    earliest_free_worker_scheduler_top #(
        .MAX_WORKERS(MAX_WORKERS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .duration(duration),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .worker_index(worker_index),
        .start_time(start_time)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic assignment_t assign_earliest_worker(
        input logic [efw_pkg::DUR_W-1:0] dur);
        int                         active;
        int                         best;
        logic [efw_pkg::TIME_W:0]   sum;
        assignment_t                result;
        active = int'(worker_count_setting);
        if (active < 1)
            active = 1;
        if (active > MAX_WORKERS)
            active = MAX_WORKERS;
        best = 0;
        for (int i = 1; i < active; i++)
        begin
            if (worker_free_time[i] < worker_free_time[best])
                best = i;
        end
        result.worker = best[efw_pkg::IDX_OUT_W-1:0];
        result.start = worker_free_time[best];
        sum = {1'b0, worker_free_time[best]} +
              {{(efw_pkg::TIME_W+1-efw_pkg::DUR_W){1'b0}}, dur};
        worker_free_time[best] = sum[efw_pkg::TIME_W] ? efw_pkg::TIME_MAX :
                                 sum[efw_pkg::TIME_W-1:0];
        return result;
    endfunction

    function automatic logic [efw_pkg::DUR_W-1:0] random_duration();
        logic [efw_pkg::DUR_W-1:0] dur;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: dur = $urandom;
            4, 5, 6:    dur = $urandom_range(0, 15);
            7:          dur = '0;
            8:          dur = DUR_MAX;
            default:    dur = 32'h1 << $urandom_range(0, efw_pkg::DUR_W - 1);
        endcase
        return dur;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] MISMATCH %s: got %0h, expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic send_request(input logic [efw_pkg::DUR_W-1:0] dur, input bit known,
                                input assignment_t typed);
        assignment_t predicted;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        duration <= dur;
        do
            @(posedge clk);
        while (in_stall);
        predicted = assign_earliest_worker(dur);
        pending_assignments.push_back(known ? typed : predicted);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_assignments.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_worker_count(input logic [efw_pkg::CNT_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        worker_count_setting = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_assignments.size() == 0)
                report_mismatch("unexpected result, worker_index", 64'(worker_index),
                                64'(0));
            else
            begin
                oldest_assignment = pending_assignments.pop_front();
                if (worker_index !== oldest_assignment.worker)
                    report_mismatch("worker_index", 64'(worker_index),
                                    64'(oldest_assignment.worker));
                if (start_time !== oldest_assignment.start)
                    report_mismatch("start_time", 64'(start_time),
                                    64'(oldest_assignment.start));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("[%0t] timeout: no request moved for %0d cycles", $time, IDLE_LIMIT);
            $display("** earliest_free_worker_scheduler_top: FAILED **");
            $finish;
        end
    end

    initial
    begin
        assignment_t typed;
        for (int i = 0; i < MAX_WORKERS; i++)
            worker_free_time[i] = '0;
        worker_count_setting = efw_pkg::COUNT_RESET;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_jobs[i])
        begin
            typed.worker = directed_jobs[i].worker;
            typed.start = directed_jobs[i].start;
            send_request(directed_jobs[i].dur, directed_jobs[i].known, typed);
        end
        drain();

        foreach (phases[p])
        begin
            write_worker_count(phases[p].count);
            send_idle_pct = phases[p].send_idle_pct;
            recv_stall_pct = phases[p].recv_stall_pct;
            hold_left = phases[p].hold_off;
            for (int j = 0; j < phases[p].jobs; j++)
                send_request(random_duration(), 1'b0, typed);
            drain();
        end

        // single worker, back-to-back maximum durations
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_worker_count(5'd1);
        for (int j = 0; j < 8; j++)
            send_request(DUR_MAX, 1'b0, typed);
        drain();

        write_worker_count(efw_pkg::COUNT_RESET);
        send_idle_pct = 26;
        recv_stall_pct = 26;
        for (int j = 0; j < 20; j++)
            send_request(random_duration(), 1'b0, typed);
        drain();

        if (mismatches == 0)
            $display("** earliest_free_worker_scheduler_top: PASSED **");
        else
            $display("** earliest_free_worker_scheduler_top: FAILED **");
        $finish;
    end

endmodule
